### rtl/core/chacha20_stream_cipher_defines.svh
// Assertion macros shared by the ChaCha20 stream cipher checkers.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef CHACHA20_STREAM_CIPHER_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CC20_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CC20_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/cc20_pkg.sv
// Shared types, constants and quarter-round function for the ChaCha20 cipher.
// No dependencies; the front end, queue, core, back end and top level refer to it.
`timescale 1ns / 1ps
`default_nettype none

package cc20_pkg;

    typedef logic [31:0]       word_t;
    typedef logic [15:0][31:0] block_t;

    // "expand 32-byte k"
    localparam word_t SIGMA0 = 32'h61707865;
    localparam word_t SIGMA1 = 32'h3320646e;
    localparam word_t SIGMA2 = 32'h79622d32;
    localparam word_t SIGMA3 = 32'h6b206574;

    // Configuration register indexes
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_NONCE_LO = 3'd4;
    localparam logic [2:0] REG_NONCE_HI = 3'd5;
    localparam logic [2:0] REG_CTR   = 3'd6;

    // Item queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [255:0] key;
        logic [95:0]  nonce;
        word_t        init_ctr;
    } cfg_t;

    // One classified byte on its way to the back end
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       first;   // first byte of a message: use the cached counter-start block
        logic [5:0] pos;     // byte position within the keystream block
    } item_t;

    typedef struct packed {
        logic  start;
        logic  abort;
        word_t ctr;
    } job_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    typedef enum logic {
        JOB_FIRST,
        JOB_NEXT
    } job_kind_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    function automatic word_t rotl(input word_t x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // Half of a quarter round: the 16/12 rotations or the 8/7 rotations.
    function automatic quad_t qr_half(input word_t a, input word_t b, input word_t c,
                                      input word_t d, input logic second);
        quad_t q;
        q.a = a + b;
        if (!second) begin
            q.d = rotl(d ^ q.a, 16);
            q.c = c + q.d;
            q.b = rotl(b ^ q.c, 12);
        end
        else begin
            q.d = rotl(d ^ q.a, 8);
            q.c = c + q.d;
            q.b = rotl(b ^ q.c, 7);
        end
        return q;
    endfunction

endpackage

`default_nettype wire

### rtl/core/cc20_fifo.sv
// Short item queue between the front end and the back end.
// Depends on cc20_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module cc20_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire cc20_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output cc20_pkg::item_t     head
);

    cc20_pkg::item_t                  mem_reg [cc20_pkg::QUEUE_DEPTH];
    logic [cc20_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [cc20_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [cc20_pkg::QPTR_W:0]        count_reg, count_next;

    assign full  = (count_reg == (cc20_pkg::QPTR_W+1)'(cc20_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/core/cc20_front.sv
// Front end: accepts input beats, tracks message start and byte position,
// and pushes classified items into the queue. Depends on cc20_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cc20_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [7:0]      s_axis_tdata,
    input  wire logic            s_axis_tlast,
    input  wire logic            queue_full,
    output logic                 push,
    output cc20_pkg::item_t      push_item
);

    logic [5:0] pos_reg, pos_next;
    logic       started_reg, started_next;

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    always_comb
    begin
        push_item.data  = s_axis_tdata;
        push_item.last  = s_axis_tlast;
        push_item.first = !started_reg;
        push_item.pos   = pos_reg;

        pos_next     = pos_reg;
        started_next = started_reg;
        if (push)
        begin
            // wrap at 64 bytes; end of message restarts the position
            pos_next     = s_axis_tlast ? 6'd0 : pos_reg + 6'd1;
            started_next = !s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            started_reg <= started_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/cc20_core.sv
// Block function core: half a quarter round on all four lanes per cycle,
// then the feed-forward add on the done cycle. Depends on cc20_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cc20_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cc20_pkg::cfg_t    cfg,
    input  wire cc20_pkg::job_t    job,
    output cc20_pkg::core_stat_t   stat,
    output cc20_pkg::block_t       blk
);

    localparam int STEPS  = DOUBLE_ROUNDS * 4;
    localparam int STEP_W = $clog2(STEPS + 1);

    cc20_pkg::block_t     w_reg, w_next;
    cc20_pkg::word_t      ctr_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg;
    logic                 last_step;

    function automatic cc20_pkg::block_t init_state(input cc20_pkg::cfg_t c,
                                                    input cc20_pkg::word_t ctr);
        cc20_pkg::block_t s;
        s[0]  = cc20_pkg::SIGMA0;
        s[1]  = cc20_pkg::SIGMA1;
        s[2]  = cc20_pkg::SIGMA2;
        s[3]  = cc20_pkg::SIGMA3;
        for (int i = 0; i < 8; i++)
        begin
            s[4+i] = c.key[32*i +: 32];
        end
        s[12] = ctr;
        s[13] = c.nonce[31:0];
        s[14] = c.nonce[63:32];
        s[15] = c.nonce[95:64];
        return s;
    endfunction

    assign last_step = (step_reg == STEP_W'(STEPS));
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && last_step;

    // feed-forward add of the input words
    always_comb
    begin
        cc20_pkg::block_t init;
        init = init_state(cfg, ctr_reg);
        for (int i = 0; i < 16; i++)
        begin
            blk[i] = w_reg[i] + init[i];
        end
    end

    // step bit 1 picks column or diagonal round, bit 0 the half of the quarter round
    always_comb
    begin
        logic [3:0]      ib, ic, id;
        cc20_pkg::quad_t q;
        w_next = w_reg;
        for (int j = 0; j < 4; j++)
        begin
            ib = step_reg[1] ? 4'(4 + ((j + 1) & 3))  : 4'(4 + j);
            ic = step_reg[1] ? 4'(8 + ((j + 2) & 3))  : 4'(8 + j);
            id = step_reg[1] ? 4'(12 + ((j + 3) & 3)) : 4'(12 + j);
            q  = cc20_pkg::qr_half(w_reg[j], w_reg[ib], w_reg[ic], w_reg[id], step_reg[0]);
            w_next[j]  = q.a;
            w_next[ib] = q.b;
            w_next[ic] = q.c;
            w_next[id] = q.d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (job.abort)
        begin
            busy_reg <= 1'b0;
        end
        else if (job.start && !busy_reg)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (last_step)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job.start && !busy_reg && !job.abort)
        begin
            w_reg   <= init_state(cfg, job.ctr);
            ctr_reg <= job.ctr;
        end
        else if (busy_reg && !last_step)
        begin
            w_reg <= w_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/cc20_back.sv
// Back end: keeps the current, next and message-start keystream blocks,
// schedules the core, XORs queued bytes and holds the output register.
// Depends on cc20_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cc20_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cc20_pkg::cfg_t       cfg,
    input  wire logic                 cfg_wr,
    input  wire logic                 queue_empty,
    input  wire cc20_pkg::item_t      head,
    output logic                      pop,
    output cc20_pkg::job_t            job,
    input  wire cc20_pkg::core_stat_t stat,
    input  wire cc20_pkg::block_t     blk,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,
    output logic                      m_axis_tlast
);

    cc20_pkg::block_t    cur_reg;
    cc20_pkg::block_t    first_blk_reg;
    cc20_pkg::block_t    next_blk_reg;
    logic                first_ok_reg, first_ok_next;
    logic                next_ok_reg, next_ok_next;
    logic                armed_reg;
    cc20_pkg::word_t     next_ctr_reg, next_ctr_next;
    cc20_pkg::job_kind_t kind_reg;
    logic                out_valid_reg;
    logic [7:0]          out_data_reg;
    logic                out_last_reg;

    logic                wrap;
    logic                ks_ok;
    logic                out_free;
    logic                pop_first, pop_wrap, flush, store;
    cc20_pkg::block_t    src;
    cc20_pkg::word_t     ks_word;
    logic [7:0]          ks_byte;
    cc20_pkg::job_kind_t kind_new;

    assign wrap     = (head.pos == 6'd0);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign ks_ok    = head.first ? first_ok_reg : (wrap ? next_ok_reg : 1'b1);
    assign pop      = !queue_empty && out_free && ks_ok;
    assign pop_first = pop && head.first;
    assign pop_wrap  = pop && !head.first && wrap;
    assign flush     = cfg_wr || pop_first;
    assign store     = stat.done && !flush;

    always_comb
    begin
        if (head.first)
        begin
            src = first_blk_reg;
        end
        else if (wrap)
        begin
            src = next_blk_reg;
        end
        else
        begin
            src = cur_reg;
        end
        ks_word = src[head.pos[5:2]];
        ks_byte = ks_word[{head.pos[1:0], 3'b000} +: 8];
    end

    // core scheduling: the message-start block first, then the next block
    always_comb
    begin
        kind_new  = first_ok_reg ? cc20_pkg::JOB_NEXT : cc20_pkg::JOB_FIRST;
        job.abort = flush;
        job.start = !stat.busy && !flush && (!first_ok_reg || (armed_reg && !next_ok_reg));
        job.ctr   = first_ok_reg ? next_ctr_reg : cfg.init_ctr;
    end

    always_comb
    begin
        first_ok_next = first_ok_reg;
        next_ok_next  = next_ok_reg;
        next_ctr_next = next_ctr_reg;
        if (store && kind_reg == cc20_pkg::JOB_FIRST)
        begin
            first_ok_next = 1'b1;
        end
        if (store && kind_reg == cc20_pkg::JOB_NEXT)
        begin
            next_ok_next = 1'b1;
        end
        if (pop_first)
        begin
            next_ok_next  = 1'b0;
            next_ctr_next = cfg.init_ctr + 32'd1;
        end
        if (pop_wrap)
        begin
            next_ok_next  = 1'b0;
            next_ctr_next = next_ctr_reg + 32'd1;
        end
        if (cfg_wr)
        begin
            first_ok_next = 1'b0;
            next_ok_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_ok_reg  <= 1'b0;
            next_ok_reg   <= 1'b0;
            armed_reg     <= 1'b0;
            next_ctr_reg  <= '0;
            kind_reg      <= cc20_pkg::JOB_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            first_ok_reg <= first_ok_next;
            next_ok_reg  <= next_ok_next;
            next_ctr_reg <= next_ctr_next;
            if (pop_first)
            begin
                armed_reg <= 1'b1;
            end
            if (job.start)
            begin
                kind_reg <= kind_new;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store && kind_reg == cc20_pkg::JOB_FIRST)
        begin
            first_blk_reg <= blk;
        end
        if (store && kind_reg == cc20_pkg::JOB_NEXT)
        begin
            next_blk_reg <= blk;
        end
        if (pop_first || pop_wrap)
        begin
            cur_reg <= src;
        end
        if (pop)
        begin
            out_data_reg <= head.data ^ ks_byte;
            out_last_reg <= head.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

### rtl/core/chacha20_stream_cipher.sv
// ChaCha20 stream cipher top level: configuration registers, front end,
// item queue, block function core and back end. Depends on cc20_pkg.
//
// Usage: write key, nonce and start counter on the cfg channel (cfg_ready is
// always high; index 0-3 key parts, 4 nonce low, 5 nonce high, 6 start counter,
// other indexes are dropped). Then stream bytes on s_axis: tdata is the byte,
// tlast marks the last byte of a message. Each beat comes back on m_axis as
// byte XOR keystream, with tlast copied. Encryption and decryption are the same.
// Once keystream is ready, a beat passes through the queue entry and the output
// register. Throughput is one byte per cycle while keystream is ready and
// m_axis_tready is high; the core builds each 64-byte block and works on the
// next block while the current one drains. A block for the start counter is
// cached, so a new message starts without a gap. After reset and after every
// configuration write the core first rebuilds that block; the first beat waits for it.
// Reset clears the registers to zero and drops all queued beats.
// When m_axis_tready is low the output beat holds; up to four more beats are
// taken into the queue before s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    // input bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_in
    input  wire logic        s_axis_tlast,   // end_of_message
    // output bytes
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] data_out
    output logic             m_axis_tlast    // last_out
);

    logic [255:0]          key_reg;
    logic [95:0]           nonce_reg;
    cc20_pkg::word_t       ctr_reg;
    cc20_pkg::cfg_t        cfg;
    logic                  cfg_wr;

    logic                  push;
    cc20_pkg::item_t       push_item;
    logic                  queue_full;
    logic                  queue_empty;
    logic                  pop;
    cc20_pkg::item_t       head;
    cc20_pkg::job_t        job;
    cc20_pkg::core_stat_t  stat;
    cc20_pkg::block_t      blk;

    // Configuration never stalls.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;

    assign cfg.key      = key_reg;
    assign cfg.nonce    = nonce_reg;
    assign cfg.init_ctr = ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            nonce_reg <= '0;
            ctr_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                cc20_pkg::REG_KEY0:     key_reg[63:0]    <= cfg_data;
                cc20_pkg::REG_KEY1:     key_reg[127:64]  <= cfg_data;
                cc20_pkg::REG_KEY2:     key_reg[191:128] <= cfg_data;
                cc20_pkg::REG_KEY3:     key_reg[255:192] <= cfg_data;
                cc20_pkg::REG_NONCE_LO: nonce_reg[63:0]  <= cfg_data;
                cc20_pkg::REG_NONCE_HI: nonce_reg[95:64] <= cfg_data[31:0];
                cc20_pkg::REG_CTR:      ctr_reg          <= cfg_data[31:0];
                default:                ; // drop writes beyond the register list
            endcase
        end
    end

    // Classify beats: message start and byte position.
    cc20_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    // Decouple the front from keystream stalls and output back-pressure.
    cc20_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .empty     (queue_empty),
        .head      (head)
    );

    // Keystream block generator.
    cc20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .job   (job),
        .stat  (stat),
        .blk   (blk)
    );

    // Block bookkeeping, XOR and output register.
    cc20_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cfg_wr        (cfg_wr),
        .queue_empty   (queue_empty),
        .head          (head),
        .pop           (pop),
        .job           (job),
        .stat          (stat),
        .blk           (blk),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### rtl/core/cc20_checker.sv
// Port-level checks for the ChaCha20 stream cipher, bound to the top level.
// Depends on chacha20_stream_cipher_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "chacha20_stream_cipher_defines.svh"

module cc20_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cfg_valid,
    input wire logic       cfg_ready,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    logic seen_in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_in_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            seen_in_reg <= 1'b1;
        end
    end

    `CC20_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed while stalled")
    `CC20_ASSERT_IMPLY(a_out_drop, $fell(m_axis_tvalid), $past(m_axis_tready), "output beat dropped without being taken")
    `CC20_ASSERT_IMPLY(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")
    `CC20_ASSERT_IMPLY(a_no_phantom, m_axis_tvalid, seen_in_reg, "output beat before any input beat")

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### tb/chacha20_stream_cipher_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the ChaCha20 stream cipher: mirrors the registers and the
// keystream state, predicts each output beat and compares it. Uses cc20_pkg.

module chacha20_stream_cipher_checker #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_in
    input  wire logic        s_axis_tlast,   // end_of_message
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,   // [7:0] data_out
    input  wire logic        m_axis_tlast,   // last_out
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cipher_byte_t;

    cipher_byte_t      cipher_bytes_due[$];
    cipher_byte_t      due;

    // mirrored registers
    logic [255:0]      key_reg;
    logic [95:0]       nonce_reg;
    cc20_pkg::word_t   start_ctr;

    // keystream position
    logic [5:0]        byte_pos;
    cc20_pkg::word_t   block_ctr;
    cc20_pkg::block_t  keystream;
    logic              in_message;

    function automatic logic [127:0] quarter_mix(input cc20_pkg::word_t a,
                                                 input cc20_pkg::word_t b,
                                                 input cc20_pkg::word_t c,
                                                 input cc20_pkg::word_t d);
        cc20_pkg::word_t wa;
        cc20_pkg::word_t wb;
        cc20_pkg::word_t wc;
        cc20_pkg::word_t wd;
        wa = a + b;   wd = d ^ wa;  wd = {wd[15:0], wd[31:16]};
        wc = c + wd;  wb = b ^ wc;  wb = {wb[19:0], wb[31:20]};
        wa = wa + wb; wd = wd ^ wa; wd = {wd[23:0], wd[31:24]};
        wc = wc + wd; wb = wb ^ wc; wb = {wb[24:0], wb[31:25]};
        return {wa, wb, wc, wd};
    endfunction

    function automatic cc20_pkg::block_t keystream_block(input logic [255:0] key,
                                                         input logic [95:0] nonce,
                                                         input cc20_pkg::word_t ctr);
        cc20_pkg::word_t  init[16];
        cc20_pkg::word_t  x[16];
        cc20_pkg::block_t blk;
        init[0] = cc20_pkg::SIGMA0;
        init[1] = cc20_pkg::SIGMA1;
        init[2] = cc20_pkg::SIGMA2;
        init[3] = cc20_pkg::SIGMA3;
        for (int i = 0; i < 8; i++)
            init[4 + i] = key[32 * i +: 32];
        init[12] = ctr;
        for (int i = 0; i < 3; i++)
            init[13 + i] = nonce[32 * i +: 32];
        x = init;
        for (int r = 0; r < DOUBLE_ROUNDS; r++)
        begin
            {x[0], x[4], x[8],  x[12]} = quarter_mix(x[0], x[4], x[8],  x[12]);
            {x[1], x[5], x[9],  x[13]} = quarter_mix(x[1], x[5], x[9],  x[13]);
            {x[2], x[6], x[10], x[14]} = quarter_mix(x[2], x[6], x[10], x[14]);
            {x[3], x[7], x[11], x[15]} = quarter_mix(x[3], x[7], x[11], x[15]);
            {x[0], x[5], x[10], x[15]} = quarter_mix(x[0], x[5], x[10], x[15]);
            {x[1], x[6], x[11], x[12]} = quarter_mix(x[1], x[6], x[11], x[12]);
            {x[2], x[7], x[8],  x[13]} = quarter_mix(x[2], x[7], x[8],  x[13]);
            {x[3], x[4], x[9],  x[14]} = quarter_mix(x[3], x[4], x[9],  x[14]);
        end
        for (int i = 0; i < 16; i++)
            blk[i] = x[i] + init[i];
        return blk;
    endfunction

    task automatic encipher_byte(input logic [7:0] data, input logic last);
        cipher_byte_t beat;
        logic [7:0]   ks_byte;
        if (!in_message)
        begin
            block_ctr  = start_ctr;
            byte_pos   = '0;
            in_message = 1'b1;
        end
        if (byte_pos == 6'd0)
            keystream = keystream_block(key_reg, nonce_reg, block_ctr);
        ks_byte   = keystream[byte_pos[5:2]][8 * byte_pos[1:0] +: 8];
        beat.data = data ^ ks_byte;
        beat.last = last;
        cipher_bytes_due.push_back(beat);
        byte_pos = byte_pos + 6'd1;
        if (byte_pos == 6'd0)
            block_ctr = block_ctr + 32'd1;
        if (last)
        begin
            byte_pos   = '0;
            in_message = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    = '0;
            nonce_reg  = '0;
            start_ctr  = '0;
            byte_pos   = '0;
            block_ctr  = '0;
            keystream  = '0;
            in_message = 1'b0;
            mismatches = 0;
            cipher_bytes_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cc20_pkg::REG_KEY0:     key_reg[63:0]    = cfg_data;
                    cc20_pkg::REG_KEY1:     key_reg[127:64]  = cfg_data;
                    cc20_pkg::REG_KEY2:     key_reg[191:128] = cfg_data;
                    cc20_pkg::REG_KEY3:     key_reg[255:192] = cfg_data;
                    cc20_pkg::REG_NONCE_LO: nonce_reg[63:0]  = cfg_data;
                    cc20_pkg::REG_NONCE_HI: nonce_reg[95:64] = cfg_data[31:0];
                    cc20_pkg::REG_CTR:      start_ctr        = cfg_data[31:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                encipher_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cipher_bytes_due.size() == 0)
                    report_mismatch($sformatf("output beat %02h last %0b with none due",
                                              m_axis_tdata, m_axis_tlast));
                else
                begin
                    due = cipher_bytes_due.pop_front();
                    if (m_axis_tdata !== due.data)
                        report_mismatch($sformatf("data_out %02h, due %02h",
                                                  m_axis_tdata, due.data));
                    if (m_axis_tlast !== due.last)
                        report_mismatch($sformatf("last_out %0b, due %0b",
                                                  m_axis_tlast, due.last));
                end
            end
        end
        outstanding <= cipher_bytes_due.size();
    end

endmodule

### tb/chacha20_stream_cipher_test.sv
`timescale 1ns / 1ps
// Top of the ChaCha20 stream cipher testbench: clock, reset, register writes,
// byte stimulus, output back-pressure and verdict. Needs cc20_pkg, the block
// and chacha20_stream_cipher_checker.

module chacha20_stream_cipher_test;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int RANDOM_BYTES  = 1400;
    localparam int PHASES        = 8;
    localparam int QUIET_LIMIT   = 4000;   // cycles with no beat on any channel
    localparam int TAIL_CYCLES   = 20;
    // index past the last register: the block must drop the write
    localparam logic [2:0] REG_SPARE = 3'd7;

    typedef enum int {
        PACE_FREE,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } pace_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic [2:0]  cfg_index     = '0;
    logic [63:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    int gap_pct      = 0;   // chance in a hundred that the sender idles a cycle
    int stall_pct    = 0;   // chance in a hundred that the receiver stalls a cycle
    int quiet_cycles = 0;
    int mismatches;
    int outstanding;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    chacha20_stream_cipher #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    chacha20_stream_cipher_checker #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Throttle the output side: drop tready on a fresh coin each cycle.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Count cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Give up once the block has been silent far longer than any correct run needs.
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("chacha20_stream_cipher_test failed");
        $finish;
    end

    // Present one register write and hold it until taken. Leave cfg_valid high:
    // the caller lowers it after the last write of a batch.
    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Write every register; the 32-bit ones get full 64-bit words so that the
    // upper bits are seen to be dropped. Now and then add a write to the spare index.
    task automatic load_config(input logic [255:0] key, input logic [63:0] nonce_lo,
                               input logic [63:0] nonce_hi, input logic [63:0] ctr);
        write_reg(cc20_pkg::REG_KEY0, key[63:0]);
        write_reg(cc20_pkg::REG_KEY1, key[127:64]);
        write_reg(cc20_pkg::REG_KEY2, key[191:128]);
        write_reg(cc20_pkg::REG_KEY3, key[255:192]);
        write_reg(cc20_pkg::REG_NONCE_LO, nonce_lo);
        write_reg(cc20_pkg::REG_NONCE_HI, nonce_hi);
        write_reg(cc20_pkg::REG_CTR, ctr);
        if ($urandom_range(1))
            write_reg(REG_SPARE, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // Offer one byte beat, idling first as the pace asks, and hold it until taken.
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Random bytes; mark the last one only when the message is to be closed.
    task automatic send_message(input int length, input bit closed);
        for (int n = 0; n < length; n++)
            send_byte(8'($urandom), closed && (n == length - 1));
    endtask

    // Stop offering and wait until every predicted beat has come back.
    // The extra edge lets the checker count the beat taken at this one.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [255:0] key;
        logic [63:0]  nonce_lo;
        logic [63:0]  nonce_hi;
        logic [63:0]  ctr;
        int           budget;
        int           len;
        int           pick;
        pace_t        pace;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Registers still hold their reset zeros here.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        // one-byte message straight after an end mark: counter reloads
        send_byte(8'hA5, 1'b1);
        drain;

        // All ones everywhere, counter at its top value.
        load_config('1, '1, '1, '1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        // open a message and leave it open across the next writes
        send_byte(8'h3C, 1'b0);
        drain;

        // New key, nonce and counter mid-message: the buffered block stays in use
        // for the rest of this block, the new counter waits for the next message.
        load_config(256'h1f1e1d1c_1b1a1918_17161514_13121110_0f0e0d0c_0b0a0908_07060504_03020100,
                    64'h4a000000_09000000, 64'hdead_beef_0000_0000, 64'h1234_5678_0000_0001);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h81, 1'b1);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h18, 1'b1);
        drain;

        // Random part: one register setting and one pace per phase.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            pace = pace_t'(phase % 4);
            case (pace)
                PACE_FREE:        begin gap_pct = 0;  stall_pct = 0;  end
                PACE_SEND_GAPS:   begin gap_pct = 56; stall_pct = 0;  end
                PACE_RECV_STALLS: begin gap_pct = 0;  stall_pct = 56; end
                default:          begin gap_pct = 10; stall_pct = 10; end
            endcase

            for (int w = 0; w < 8; w++)
                key[32 * w +: 32] = $urandom;
            nonce_lo = {$urandom, $urandom};
            nonce_hi = {$urandom, $urandom};
            ctr      = {$urandom, $urandom};
            case (phase)
                0: ctr[31:0] = 32'hFFFF_FFFF;       // counter wraps inside a message
                1: begin key = '1; nonce_lo = '1; nonce_hi = '1; ctr = '1; end
                2: begin key = '0; nonce_lo = '0; nonce_hi = '0; ctr = '0; end
                5: ctr[31:0] = 32'hFFFF_FFFE;
                default: ;
            endcase
            // The previous phase may have left a message open: this lands mid-message.
            load_config(key, nonce_lo, nonce_hi, ctr);

            budget = RANDOM_BYTES / PHASES;
            if (phase < 2)
            begin
                // three blocks from the top counter value: wrap to zero and beyond
                send_message(130, 1'b1);
                budget -= 130;
            end
            while (budget > 0)
            begin
                pick = $urandom_range(9);
                if (pick < 2)
                    len = $urandom_range(1, 4);
                else if (pick < 9)
                    len = $urandom_range(5, 70);
                else
                    len = $urandom_range(65, 200);
                if (len > budget)
                    len = budget;
                // only the last message of a phase may stay open
                send_message(len, (len < budget) || $urandom_range(1));
                budget -= len;
            end
            drain;
        end

        // Let any stray beat show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("chacha20_stream_cipher_test passed");
        else
            $display("chacha20_stream_cipher_test failed");
        $finish;
    end

endmodule
